/* src/epc_pkg.sv */
// shared types and constants for the equal pair counter
`default_nettype none

package epc_pkg;

  // default table size and job length limit
  localparam int unsigned      TableDepthDef = 1024;
  localparam longint unsigned  MaxItemsDef   = 65535;

  // multiplicative hash constant (golden ratio)
  localparam logic [31:0] HashMult = 32'h9E37_79B1;

  // saturation limits
  localparam logic [15:0] CountMax = 16'hFFFF;

  // one table slot as held in memory
  typedef struct packed {
    logic        valid;
    logic [31:0] key;
    logic [15:0] first_cnt;
    logic [15:0] second_cnt;
  } slot_t;

  // sequencer states, one-hot
  typedef enum logic [8:0] {
    S_SWEEP = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_HASH  = 9'b000000100,
    S_RECIP = 9'b000001000,
    S_MODR  = 9'b000010000,
    S_FIX   = 9'b000100000,
    S_READ  = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_EMIT  = 9'b100000000
  } state_e;

endpackage

`default_nettype wire

/* src/equal_pair_counter.sv */
// top level of the equal pair counter: hash table, shared multiplier and sequencer
//
// Input channel (in_valid_i / in_stall_o) carries one element per beat: a 32-bit
// value, the set it belongs to (cmd_i) and an end-of-job mark (last_i). Each
// element probes a linear-probing hash table of TABLE_DEPTH slots, bumps its own
// set's count and adds the other set's count to a running total.
// The beat marked last yields one result beat on the output channel
// (out_valid_o / out_stall_i): the pair total and an overflow flag.
// An element keeps the block busy (in_stall_o high) until its last probe is
// checked, so a new beat is taken only once the previous element is done; every
// extra probe past the home slot adds a read and a check. The shared 32x32
// multiplier runs three times (hash, reciprocal, remainder) and each probe needs
// a table read state and a check/write state. A last element then enters an emit
// state, which loads the result register once the output register is free, and
// then a clearing pass over all TABLE_DEPTH slots runs before the next element.
// After reset the same clearing pass over all TABLE_DEPTH slots runs before the
// first element is accepted. The result sits in an output register; while the
// receiver stalls it holds, and the block keeps taking elements until a further
// result is ready to replace it.
`default_nettype none

module equal_pair_counter #(
  parameter int unsigned     TABLE_DEPTH = epc_pkg::TableDepthDef,
  parameter longint unsigned MAX_ITEMS   = epc_pkg::MaxItemsDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] value_i,
  input  wire logic        cmd_i,
  input  wire logic        last_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [32:0]      pair_total_o,
  output logic             overflow_o
);
  import epc_pkg::*;

  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ItemW = $clog2(MAX_ITEMS + 2);
  localparam logic [32:0] RecipW   = 33'((64'd1 << 32) / TABLE_DEPTH);
  localparam logic [16:0] DepthW   = 17'(TABLE_DEPTH);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_DEPTH - 1);
  localparam logic [ItemW-1:0] ItemLim = ItemW'(MAX_ITEMS);
  localparam logic [ItemW-1:0] ItemSat = ItemW'(MAX_ITEMS + 1);

  state_e state_q, state_d;

  // element registers
  logic [31:0] key_q;
  logic        sel_q;
  logic        last_q;
  logic [15:0] h_q, h_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  // probe control
  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] tries_q, tries_d;
  logic [IdxW-1:0] swp_q, swp_d;

  // job state
  logic [32:0]      total_q, total_d;
  logic             ovf_q, ovf_d;
  logic [ItemW-1:0] items_q, items_d;

  // result register
  logic        out_valid_q, out_valid_d;
  logic [32:0] res_total_q;
  logic        res_ovf_q;
  logic        res_load;

  // table memory
  slot_t           mem_q [TABLE_DEPTH];
  slot_t           rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  slot_t           mem_wdata;

  // remainder correction and slot update helpers
  logic [16:0] rem_raw, rem_fix;
  logic [15:0] own_cnt, other_cnt, own_next;
  logic [33:0] sum_w;
  logic        in_take;

  assign in_stall_o   = (state_q != S_IDLE);
  assign in_take      = in_valid_i && (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign pair_total_o = res_total_q;
  assign overflow_o   = res_ovf_q;

  // operand select for the shared multiplier
  always_comb begin
    case (state_q)
      S_HASH: begin
        mul_a = key_q;
        mul_b = HashMult;
      end
      S_RECIP: begin
        mul_a = {16'h0000, prod_q[31:16]};
        mul_b = RecipW[31:0];
      end
      S_MODR: begin
        mul_a = {16'h0000, prod_q[47:32]};
        mul_b = {15'h0, DepthW};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  // remainder h - q*D, one correction step
  assign rem_raw = {1'b0, h_q} - prod_q[16:0];
  assign rem_fix = (rem_raw >= DepthW) ? (rem_raw - DepthW) : rem_raw;

  // count update on a key match
  assign own_cnt   = sel_q ? rd_q.second_cnt : rd_q.first_cnt;
  assign other_cnt = sel_q ? rd_q.first_cnt  : rd_q.second_cnt;
  assign own_next  = (own_cnt == CountMax) ? own_cnt : own_cnt + 16'd1;
  assign sum_w     = {1'b0, total_q} + {18'h0, other_cnt};

  // sequencer
  always_comb begin
    state_d     = state_q;
    h_d         = h_q;
    idx_d       = idx_q;
    tries_d     = tries_q;
    swp_d       = swp_q;
    total_d     = total_q;
    ovf_d       = ovf_q;
    items_d     = items_q;
    out_valid_d = out_valid_q;
    res_load    = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = idx_q;
    mem_wdata   = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = swp_q;
        swp_d     = swp_q + 1'b1;
        if (swp_q == LastIdx) begin
          swp_d   = '0;
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_take) begin
          if (items_q != ItemSat) begin
            items_d = items_q + 1'b1;
          end
          if (items_q >= ItemLim) begin
            ovf_d = 1'b1;
          end
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        state_d = S_RECIP;
      end
      S_RECIP: begin
        h_d     = prod_q[31:16];
        state_d = S_MODR;
      end
      S_MODR: begin
        state_d = S_FIX;
      end
      S_FIX: begin
        idx_d   = rem_fix[IdxW-1:0];
        tries_d = '0;
        state_d = S_READ;
      end
      S_READ: begin
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_q.valid) begin
          // free slot: insert the key
          mem_we               = 1'b1;
          mem_wdata.valid      = 1'b1;
          mem_wdata.key        = key_q;
          mem_wdata.first_cnt  = sel_q ? 16'd0 : 16'd1;
          mem_wdata.second_cnt = sel_q ? 16'd1 : 16'd0;
          state_d              = last_q ? S_EMIT : S_IDLE;
        end else if (rd_q.key == key_q) begin
          // key hit: bump own count, add the other one
          mem_we    = 1'b1;
          mem_wdata = rd_q;
          if (sel_q) begin
            mem_wdata.second_cnt = own_next;
          end else begin
            mem_wdata.first_cnt = own_next;
          end
          if (own_cnt == CountMax || sum_w[33]) begin
            ovf_d = 1'b1;
          end
          total_d = sum_w[33] ? '1 : sum_w[32:0];
          state_d = last_q ? S_EMIT : S_IDLE;
        end else if (tries_q == LastIdx) begin
          // table full, element dropped
          ovf_d   = 1'b1;
          state_d = last_q ? S_EMIT : S_IDLE;
        end else begin
          tries_d = tries_q + 1'b1;
          idx_d   = (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
          state_d = S_READ;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          res_load    = 1'b1;
          out_valid_d = 1'b1;
          total_d     = '0;
          ovf_d       = 1'b0;
          items_d     = '0;
          swp_d       = '0;
          state_d     = S_SWEEP;
        end
      end
      default: begin
        state_d = S_SWEEP;
        swp_d   = '0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_SWEEP;
      swp_q       <= '0;
      total_q     <= '0;
      ovf_q       <= 1'b0;
      items_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      swp_q       <= swp_d;
      total_q     <= total_d;
      ovf_q       <= ovf_d;
      items_q     <= items_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      key_q  <= value_i;
      sel_q  <= cmd_i;
      last_q <= last_i;
    end
    h_q     <= h_d;
    idx_q   <= idx_d;
    tries_q <= tries_d;
    if (res_load) begin
      res_total_q <= total_q;
      res_ovf_q   <= ovf_q;
    end
  end

  // table memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

endmodule

`default_nettype wire
